// ===== rtl/core/u8v_pkg.sv =====
// ----------------------------------------------------------------------------
// u8v_pkg
// Shared types and constants for the UTF-8 stream validator.
// ----------------------------------------------------------------------------
package u8v_pkg;

  localparam int unsigned PendW = 2;
  localparam int unsigned CheckW = 4;

  // Extra checks applied to the next continuation byte.
  localparam logic [CheckW-1:0] CkNone      = 4'd0;
  localparam logic [CheckW-1:0] CkAfterE0   = 4'd1;
  localparam logic [CheckW-1:0] CkAfterED   = 4'd2;
  localparam logic [CheckW-1:0] CkAfterEF   = 4'd3;
  localparam logic [CheckW-1:0] CkNoFffx    = 4'd4;
  localparam logic [CheckW-1:0] CkAfterF0   = 4'd5;
  localparam logic [CheckW-1:0] CkAfterF4   = 4'd6;
  localparam logic [CheckW-1:0] CkAfterEFB7 = 4'd7;
  localparam logic [CheckW-1:0] CkAfterF1F3 = 4'd8;
  localparam logic [CheckW-1:0] CkPlaneEnd  = 4'd9;

  localparam logic [7:0] ByteAsciiEnd  = 8'h80;
  localparam logic [7:0] ByteLeadMin   = 8'hC2;
  localparam logic [7:0] ByteLead3     = 8'hE0;
  localparam logic [7:0] ByteLead4     = 8'hF0;
  localparam logic [7:0] ByteLeadLimit = 8'hF5;
  localparam logic [7:0] ByteED        = 8'hED;
  localparam logic [7:0] ByteEF        = 8'hEF;
  localparam logic [7:0] ByteF4        = 8'hF4;
  localparam logic [7:0] ByteB7        = 8'hB7;
  localparam logic [7:0] ByteBE        = 8'hBE;
  localparam logic [7:0] ByteBF        = 8'hBF;
  localparam logic [7:0] ByteAF        = 8'hAF;
  localparam logic [7:0] Byte9F        = 8'h9F;
  localparam logic [7:0] Byte8F        = 8'h8F;
  localparam logic [7:0] Byte90        = 8'h90;
  localparam logic [7:0] ByteA0        = 8'hA0;

  typedef struct packed {
    logic [PendW-1:0]  pending;
    logic [CheckW-1:0] check;
  } dec_state_t;

  function automatic logic is_plane_end(input logic [7:0] b);
    return (b == Byte8F) || (b == Byte9F) || (b == ByteAF) || (b == ByteBF);
  endfunction

endpackage

// ===== rtl/core/u8v_step.sv =====
// ----------------------------------------------------------------------------
// u8v_step
// Decoder state update and verdict for one byte or end-of-stream item.
// ----------------------------------------------------------------------------
module u8v_step
  import u8v_pkg::*;
(
  input  dec_state_t cur_i,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_stream_i,
  output dec_state_t nxt_o,
  output logic       ok_o
);

  logic       bad;
  logic [7:0] b;

  assign b = data_byte_i;

  always_comb begin
    nxt_o = cur_i;
    ok_o  = 1'b1;
    bad   = 1'b0;
    if (end_of_stream_i) begin
      if (cur_i.pending != '0) begin
        ok_o = 1'b0;
        nxt_o.pending = '0;
      end
    end else if (cur_i.pending == '0) begin
      nxt_o.check = CkNone;
      if (b < ByteAsciiEnd) begin
        ok_o = 1'b1;
      end else if ((b < ByteLeadMin) || (b >= ByteLeadLimit)) begin
        ok_o = 1'b0;
      end else if (b < ByteLead3) begin
        nxt_o.pending = 2'd1;
      end else if (b < ByteLead4) begin
        nxt_o.pending = 2'd2;
        if (b == ByteLead3) nxt_o.check = CkAfterE0;
        else if (b == ByteED) nxt_o.check = CkAfterED;
        else if (b == ByteEF) nxt_o.check = CkAfterEF;
      end else begin
        nxt_o.pending = 2'd3;
        if (b == ByteLead4) nxt_o.check = CkAfterF0;
        else if (b == ByteF4) nxt_o.check = CkAfterF4;
        else nxt_o.check = CkAfterF1F3;
      end
    end else if (b[7:6] != 2'b10) begin
      ok_o = 1'b0;
      nxt_o.pending = '0;
    end else begin
      nxt_o.check = CkNone;
      unique case (cur_i.check)
        CkAfterE0: bad = (b <= Byte9F);
        CkAfterED: bad = (b >= ByteA0);
        CkAfterEF: begin
          if (b == ByteBF) nxt_o.check = CkNoFffx;
          else if (b == ByteB7) nxt_o.check = CkAfterEFB7;
        end
        CkNoFffx: bad = (b == ByteBE) || (b == ByteBF);
        CkAfterF0: begin
          bad = (b < Byte90);
          if (is_plane_end(b)) nxt_o.check = CkPlaneEnd;
        end
        CkAfterF4: begin
          bad = (b > Byte8F);
          if (b == Byte8F) nxt_o.check = CkPlaneEnd;
        end
        CkAfterEFB7: bad = (b >= Byte90) && (b <= ByteAF);
        CkAfterF1F3: begin
          if (is_plane_end(b)) nxt_o.check = CkPlaneEnd;
        end
        CkPlaneEnd: begin
          if (b == ByteBF) nxt_o.check = CkNoFffx;
        end
        default: bad = 1'b0;
      endcase
      if (bad) begin
        ok_o = 1'b0;
        nxt_o.pending = '0;
      end else begin
        nxt_o.pending = cur_i.pending - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/core/utf8_stream_validator_core.sv =====
// ----------------------------------------------------------------------------
// utf8_stream_validator_core
// Strict UTF-8 stream checker: one verdict per byte or end-of-stream item.
// ----------------------------------------------------------------------------
//  channel | handshake                  | payload
//  in      | in_valid_i / in_ready_o    | data_byte_i, end_of_stream_i
//  out     | out_valid_o / out_ready_i  | valid_res_o
//
// An item sits in the input register, where the decoder state is
// updated, and its verdict then waits in the result register.
// The core takes one item per clock while the output is not stalled.
// Reset clears both registers' valid flags and the decoder state.
// A stalled output holds the result and, once the input register is full,
// stops acceptance; in_ready_o follows out_ready_i combinationally.
// ----------------------------------------------------------------------------
module utf8_stream_validator_core
  import u8v_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_stream_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       valid_res_o
);

  logic       in_full_q;
  logic [7:0] byte_q;
  logic       eos_q;
  dec_state_t state_q;
  dec_state_t state_d;
  logic       ok_d;
  logic       out_full_q;
  logic       res_q;
  logic       advance;

  assign advance    = in_full_q && (!out_full_q || out_ready_i);
  assign in_ready_o = !in_full_q || advance;

  u8v_step u_step (
    .cur_i          (state_q),
    .data_byte_i    (byte_q),
    .end_of_stream_i(eos_q),
    .nxt_o          (state_d),
    .ok_o           (ok_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q  <= 1'b0;
      out_full_q <= 1'b0;
      state_q    <= '0;
    end else begin
      if (in_ready_o) begin
        in_full_q <= in_valid_i;
      end
      if (advance) begin
        state_q    <= state_d;
        out_full_q <= 1'b1;
      end else if (out_ready_i) begin
        out_full_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= data_byte_i;
      eos_q  <= end_of_stream_i;
    end
    if (advance) begin
      res_q <= ok_d;
    end
  end

  assign out_valid_o = out_full_q;
  assign valid_res_o = res_q;

endmodule

// ===== dv/utf8_verdict_checker.sv =====
// ----------------------------------------------------------------------------
// utf8_verdict_checker
// Watches both channels of the UTF-8 stream validator. It keeps its own copy
// of the decoder state, works out the verdict of every accepted item, and
// compares each delivered verdict with the oldest one still owed.
// ----------------------------------------------------------------------------
module utf8_verdict_checker
  import u8v_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_stream_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        valid_res_i,
  output int unsigned mismatch_count_o,
  output int unsigned verdicts_owed_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic       verdict;
    logic [7:0] data;
    logic       eos;
  } verdict_rec_t;

  verdict_rec_t verdict_q[$];
  verdict_rec_t fresh;
  verdict_rec_t oldest;
  dec_state_t   dec_q;
  int unsigned  errors;
  int unsigned  seen;

  function automatic logic predict_verdict(input logic [7:0] b, input logic eos);
    logic [CheckW-1:0] cur;
    logic              ok;
    logic              plane_end;
    plane_end = (b == Byte8F) || (b == Byte9F) || (b == ByteAF) || (b == ByteBF);
    if (eos) begin
      ok = (dec_q.pending == '0);
      dec_q.pending = '0;
      return ok;
    end
    if (dec_q.pending == '0) begin
      dec_q.check = CkNone;
      if (b < ByteAsciiEnd) return 1'b1;
      if (b < ByteLeadMin || b >= ByteLeadLimit) return 1'b0;
      if (b < ByteLead3) begin
        dec_q.pending = 2'd1;
      end else if (b < ByteLead4) begin
        dec_q.pending = 2'd2;
        if (b == ByteLead3) dec_q.check = CkAfterE0;
        else if (b == ByteED) dec_q.check = CkAfterED;
        else if (b == ByteEF) dec_q.check = CkAfterEF;
      end else begin
        dec_q.pending = 2'd3;
        if (b == ByteLead4) dec_q.check = CkAfterF0;
        else if (b == ByteF4) dec_q.check = CkAfterF4;
        else dec_q.check = CkAfterF1F3;
      end
      return 1'b1;
    end
    if (b[7:6] != 2'b10) begin
      dec_q.pending = '0;
      return 1'b0;
    end
    cur = dec_q.check;
    dec_q.check = CkNone;
    ok = 1'b1;
    case (cur)
      CkAfterE0: ok = (b > Byte9F);
      CkAfterED: ok = (b < ByteA0);
      CkAfterEF: begin
        if (b == ByteBF) dec_q.check = CkNoFffx;
        else if (b == ByteB7) dec_q.check = CkAfterEFB7;
      end
      CkNoFffx: ok = (b != ByteBE) && (b != ByteBF);
      CkAfterF0: begin
        ok = (b >= Byte90);
        if (ok && plane_end) dec_q.check = CkPlaneEnd;
      end
      CkAfterF4: begin
        ok = (b <= Byte8F);
        if (b == Byte8F) dec_q.check = CkPlaneEnd;
      end
      CkAfterEFB7: ok = !((b >= Byte90) && (b <= ByteAF));
      CkAfterF1F3: begin
        if (plane_end) dec_q.check = CkPlaneEnd;
      end
      CkPlaneEnd: begin
        if (b == ByteBF) dec_q.check = CkNoFffx;
      end
      default: ;
    endcase
    if (ok) dec_q.pending = dec_q.pending - 1'b1;
    else dec_q.pending = '0;
    return ok;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_q = '0;
      verdict_q.delete();
      errors = 0;
      seen = 0;
      mismatch_count_o <= 0;
      verdicts_owed_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        fresh.verdict = predict_verdict(data_byte_i, end_of_stream_i);
        fresh.data = data_byte_i;
        fresh.eos = end_of_stream_i;
        verdict_q.push_back(fresh);
      end
      if (out_valid_i && out_ready_i) begin
        if (verdict_q.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("verdict %0b delivered with no item outstanding", valid_res_i);
          end
        end else begin
          oldest = verdict_q.pop_front();
          if (valid_res_i !== oldest.verdict) begin
            errors++;
            if (errors <= 10) begin
              $display("verdict mismatch on item %0d (data %02h, eos %0b): expected %0b, got %0b",
                       seen, oldest.data, oldest.eos, oldest.verdict, valid_res_i);
            end
          end
        end
        seen++;
      end
      mismatch_count_o <= errors;
      verdicts_owed_o <= verdict_q.size();
    end
  end

endmodule

// ===== dv/tb_utf8_stream_validator_core.sv =====
// ----------------------------------------------------------------------------
// tb_utf8_stream_validator_core
// Drives a byte stream into the UTF-8 validator: a short directed run over
// boundary bytes and the rejected forms, then mostly well-formed sequences
// with biased content, broken sequences, noise and end markers. Both sides
// idle at random and the receiver once stalls long enough to back up the
// input. The checker instance predicts and compares every verdict.
// ----------------------------------------------------------------------------
module tb_utf8_stream_validator_core
  import u8v_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumItems      = 650;
  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned LongHold      = 80;
  localparam int unsigned DrainCycles   = 8;

  typedef struct packed {
    logic [7:0] data;
    logic       eos;
  } stream_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        end_of_stream_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        valid_res_o;
  int unsigned mismatch_count;
  int unsigned verdicts_owed;
  int unsigned items_sent = 0;
  int unsigned idle_cycles = 0;

  stream_item_t stream_q[$];

  always #5ns clk_i = ~clk_i;

  utf8_stream_validator_core dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .data_byte_i,
    .end_of_stream_i,
    .out_valid_o,
    .out_ready_i,
    .valid_res_o
  );

  utf8_verdict_checker u_checker (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_i      (in_ready_o),
    .data_byte_i,
    .end_of_stream_i,
    .out_valid_i     (out_valid_o),
    .out_ready_i,
    .valid_res_i     (valid_res_o),
    .mismatch_count_o(mismatch_count),
    .verdicts_owed_o (verdicts_owed)
  );

  function automatic int unsigned pick_idle_cycles();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] pick_lead();
    case ($urandom_range(0, 9))
      0: return 8'($urandom_range(ByteLeadMin, 8'hDF));
      1: return ByteLead3;
      2: return ByteED;
      3, 8: return ByteEF;
      4: return 8'($urandom_range(ByteLead3, 8'hEF));
      5: return ByteLead4;
      6: return ByteF4;
      7: return 8'($urandom_range(8'hF1, 8'hF3));
      default: return 8'($urandom_range(ByteLead4, ByteF4));
    endcase
  endfunction

  function automatic logic [7:0] pick_continuation();
    case ($urandom_range(0, 15))
      0: return Byte8F;
      1: return Byte9F;
      2: return ByteAF;
      3: return ByteBF;
      4: return ByteB7;
      5: return ByteBE;
      6: return Byte90;
      7: return ByteA0;
      default: return 8'($urandom_range(8'h80, 8'hBF));
    endcase
  endfunction

  function automatic int unsigned tail_length(input logic [7:0] lead);
    if (lead < ByteLead3) return 1;
    if (lead < ByteLead4) return 2;
    return 3;
  endfunction

  task automatic push_item(input logic [7:0] data, input logic eos);
    stream_item_t item;
    item.data = data;
    item.eos = eos;
    stream_q.push_back(item);
  endtask

  task automatic build_stream();
    int unsigned kind;
    int unsigned n;
    logic [7:0]  lead;
    push_item(8'h00, 1'b0);
    push_item(8'h7F, 1'b0);
    push_item(ByteAsciiEnd, 1'b0);
    push_item(8'hC1, 1'b0);
    push_item(ByteLeadLimit, 1'b0);
    push_item(8'hFF, 1'b0);
    push_item(ByteLeadMin, 1'b0);
    push_item(ByteAsciiEnd, 1'b0);
    push_item(ByteLead3, 1'b0);
    push_item(ByteAsciiEnd, 1'b0);
    push_item(ByteED, 1'b0);
    push_item(ByteA0, 1'b0);
    push_item(ByteEF, 1'b0);
    push_item(ByteB7, 1'b0);
    push_item(Byte90, 1'b0);
    push_item(ByteEF, 1'b0);
    push_item(ByteBF, 1'b0);
    push_item(ByteBE, 1'b0);
    push_item(ByteF4, 1'b0);
    push_item(Byte90, 1'b0);
    push_item(8'hE2, 1'b0);
    push_item(8'h41, 1'b0);
    push_item(ByteLeadMin, 1'b0);
    push_item(8'hA5, 1'b1);
    push_item(8'hFF, 1'b1);
    while (stream_q.size() < NumItems) begin
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
        push_item(8'($urandom_range(0, 127)), 1'b0);
      end else if (kind < 75) begin
        lead = pick_lead();
        push_item(lead, 1'b0);
        repeat (tail_length(lead)) push_item(pick_continuation(), 1'b0);
      end else if (kind < 85) begin
        lead = pick_lead();
        push_item(lead, 1'b0);
        n = $urandom_range(0, tail_length(lead) - 1);
        repeat (n) push_item(pick_continuation(), 1'b0);
        push_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else if (kind < 94) begin
        push_item(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        push_item(8'($urandom_range(0, 255)), 1'b1);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("tb_utf8_stream_validator_core: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned run;
    int unsigned stall;
    bit          held;
    held = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      run = $urandom_range(1, 30);
      out_ready_i <= 1'b1;
      repeat (run) @(posedge clk_i);
      if (!held && items_sent >= 150) begin
        held = 1'b1;
        stall = LongHold;
      end else begin
        stall = pick_idle_cycles();
      end
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  initial begin
    int unsigned gap;
    build_stream();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (stream_q[i]) begin
      gap = ((i / 48) % 4 == 2) ? 0 : pick_idle_cycles();
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      data_byte_i <= stream_q[i].data;
      end_of_stream_i <= stream_q[i].eos;
      @(posedge clk_i);
      while (!in_ready_o) @(posedge clk_i);
      items_sent++;
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (verdicts_owed != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_utf8_stream_validator_core: PASS");
    end else begin
      $display("tb_utf8_stream_validator_core: FAIL");
    end
    $finish;
  end

endmodule
